// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// a must hold on every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst, a) \
   label: assert property (@(posedge clk) disable iff (rst) (a)) \
      else $error("assertion failed");
// b must hold in the cycle where a holds
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// b must hold in the cycle after a
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, a)
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: hdl/dpsp_pkg.sv
package dpsp_pkg;

   localparam int VOLT_W    = 13;
   localparam int MARGIN_W  = 10;
   localparam int TRAVEL_W  = 8;
   localparam int FLAG_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_STEPS = TRAVEL_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int FLAG_DEV_BIT = 0;
   localparam int FLAG_A_BIT   = 1;
   localparam int FLAG_B_BIT   = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_MIN,
      CSR_A_MAX,
      CSR_B_MIN,
      CSR_B_MAX,
      CSR_MARGIN,
      CSR_DEV_LIMIT,
      CSR_FAULT_LIMIT,
      CSR_DEADZONE
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic                done;
      logic                in_window;
      logic [TRAVEL_W-1:0] travel;
   } lane_result_type;

endpackage

// File: hdl/dpsp_lane.sv
`include "assert_macros.svh"

module dpsp_lane
   import dpsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VOLT_W-1:0]   sample,
   input  logic [VOLT_W-1:0]   lo,
   input  logic [VOLT_W-1:0]   hi,
   input  logic [MARGIN_W-1:0] margin,
   output lane_result_type     result
);

   logic [VOLT_W-1:0]   rem_ff, rem_in;
   logic [TRAVEL_W-1:0] num_ff, num_in;
   logic [TRAVEL_W-1:0] quo_ff, quo_in;
   logic [VOLT_W-1:0]   span_ff, span_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                ok_ff, ok_in;
   logic                zero_ff, zero_in;

   logic [VOLT_W:0]          lower_sum, upper_sum;
   logic [VOLT_W-1:0]        clamped, offset;
   logic [VOLT_W+TRAVEL_W-1:0] product;
   logic [VOLT_W:0]          trial;
   logic                     fits;

   always_comb begin
      // window test without going negative: v + m >= lo, v <= hi + m
      lower_sum = {1'b0, sample} + {{(VOLT_W+1-MARGIN_W){1'b0}}, margin};
      upper_sum = {1'b0, hi} + {{(VOLT_W+1-MARGIN_W){1'b0}}, margin};
      ok_in     = (lower_sum >= {1'b0, lo}) && ({1'b0, sample} <= upper_sum);

      if (sample < lo) begin
         clamped = lo;
      end else if (sample > hi) begin
         clamped = hi;
      end else begin
         clamped = sample;
      end
      offset  = clamped - lo;
      // offset * 255
      product = {offset, {TRAVEL_W{1'b0}}} - {{TRAVEL_W{1'b0}}, offset};

      trial = {rem_ff, num_ff[TRAVEL_W-1]};
      fits  = trial >= {1'b0, span_ff};

      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      span_in = span_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      zero_in = zero_ff;

      if (start) begin
         // quotient fits in 8 bits, so the top bits already sit below span
         rem_in  = product[VOLT_W+TRAVEL_W-1:TRAVEL_W];
         num_in  = product[TRAVEL_W-1:0];
         quo_in  = '0;
         span_in = hi - lo;
         zero_in = (hi <= lo);
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? VOLT_W'(trial - {1'b0, span_ff}) : trial[VOLT_W-1:0];
         num_in  = {num_ff[TRAVEL_W-2:0], 1'b0};
         quo_in  = {quo_ff[TRAVEL_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      span_ff <= span_in;
      zero_ff <= zero_in;
      if (start) begin
         ok_ff <= ok_in;
      end
   end

   assign result.done      = done_ff;
   assign result.in_window = ok_ff;
   assign result.travel    = zero_ff ? '0 : quo_ff;

   `ASSERT_IMPLIES(a_rem_below_span, clock, reset, busy_ff && !zero_ff, rem_ff < span_ff)
   `ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && !done_ff)
   `ASSERT_ALWAYS(a_busy_done_excl, clock, reset, !(busy_ff && done_ff))

endmodule

// File: hdl/dpsp_merge.sv
`include "assert_macros.svh"

module dpsp_merge
   import dpsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  logic                ignore_errors,
   input  logic [TRAVEL_W-1:0] deviation_limit,
   input  logic [TRAVEL_W-1:0] fault_limit,
   input  logic [TRAVEL_W-1:0] travel_deadzone,
   input  lane_result_type     lane_a,
   input  lane_result_type     lane_b,
   output logic [TRAVEL_W-1:0] travel,
   output logic [FLAG_W-1:0]   error_flags
);

   logic [TRAVEL_W-1:0] fault_count_ff, fault_count_in;
   logic [TRAVEL_W-1:0] diff, average;
   logic [TRAVEL_W:0]   sum;
   logic                allowed, both_ok, good;

   always_comb begin
      both_ok = lane_a.in_window && lane_b.in_window;
      diff    = (lane_a.travel >= lane_b.travel) ? lane_a.travel - lane_b.travel
                                                 : lane_b.travel - lane_a.travel;
      sum     = {1'b0, lane_a.travel} + {1'b0, lane_b.travel};
      average = sum[TRAVEL_W:1];
      good    = both_ok && (diff < deviation_limit);
      allowed = (fault_count_ff > fault_limit) && !ignore_errors;

      travel      = '0;
      error_flags = '0;
      fault_count_in = fault_count_ff;

      if (good) begin
         travel         = (average <= travel_deadzone) ? '0 : average;
         fault_count_in = '0;
      end else if (allowed) begin
         error_flags[FLAG_DEV_BIT] = both_ok;
         error_flags[FLAG_A_BIT]   = !lane_a.in_window;
         error_flags[FLAG_B_BIT]   = !lane_b.in_window;
      end else if (fault_count_ff != '1) begin
         fault_count_in = fault_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_count_ff <= '0;
      end else if (update) begin
         fault_count_ff <= fault_count_in;
      end
   end

   `ASSERT_IMPLIES(a_merge_lanes_done, clock, reset, update, lane_a.done && lane_b.done)
   `ASSERT_IMPLIES(a_flags_need_count, clock, reset, error_flags != '0, allowed)
   `ASSERT_NEXT(a_good_clears, clock, reset, update && good, fault_count_ff == '0)

endmodule

// File: hdl/dual_pedal_sensor_plausibility.sv
// Channel  Ports                              Direction
// req      req_valid/ready, sample_a/b        in, one sensor pair per transfer
// rsp      rsp_valid/ready, travel, flags     out, one result per transfer
// csr      csr_write_enable, index, data      in, write only, no wait
//
// A pair goes from req transfer to rsp_valid in order: the transfer edge
// loads both lanes, then the divider runs (one quotient bit a cycle) and
// the merge step loads the output register, which drives rsp_valid.
// A new pair is taken once the previous one has left the lanes, even while its
// result still waits in the output register; a stalled rsp holds the lanes.
// Synchronous reset restores the register defaults and a zero fault count.
`include "assert_macros.svh"

module dual_pedal_sensor_plausibility
   import dpsp_pkg::*;
#(
   parameter bit IGNORE_ERRORS = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [VOLT_W-1:0]    req_sample_a,
   input  logic [VOLT_W-1:0]    req_sample_b,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TRAVEL_W-1:0]  rsp_travel,
   output logic [FLAG_W-1:0]    rsp_error_flags,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VOLT_W-1:0]    csr_data
);

   logic [VOLT_W-1:0]   a_min_ff, a_max_ff, b_min_ff, b_max_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic [TRAVEL_W-1:0] dev_limit_ff, fault_limit_ff, deadzone_ff;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TRAVEL_W-1:0] rsp_travel_ff;
   logic [FLAG_W-1:0]   rsp_flags_ff;

   logic                start, merge_load;
   lane_result_type     lane_a, lane_b;
   logic [TRAVEL_W-1:0] merge_travel;
   logic [FLAG_W-1:0]   merge_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_min_ff       <= VOLT_W'(500);
         a_max_ff       <= VOLT_W'(4500);
         b_min_ff       <= VOLT_W'(500);
         b_max_ff       <= VOLT_W'(4500);
         margin_ff      <= MARGIN_W'(100);
         dev_limit_ff   <= TRAVEL_W'(25);
         fault_limit_ff <= TRAVEL_W'(3);
         deadzone_ff    <= TRAVEL_W'(5);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_A_MIN:       a_min_ff       <= csr_data;
            CSR_A_MAX:       a_max_ff       <= csr_data;
            CSR_B_MIN:       b_min_ff       <= csr_data;
            CSR_B_MAX:       b_max_ff       <= csr_data;
            CSR_MARGIN:      margin_ff      <= csr_data[MARGIN_W-1:0];
            CSR_DEV_LIMIT:   dev_limit_ff   <= csr_data[TRAVEL_W-1:0];
            CSR_FAULT_LIMIT: fault_limit_ff <= csr_data[TRAVEL_W-1:0];
            CSR_DEADZONE:    deadzone_ff    <= csr_data[TRAVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      start        = 1'b0;
      merge_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               start    = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // output register must be free or draining this cycle
            if (lane_a.done && lane_b.done && (!rsp_valid_ff || rsp_ready)) begin
               merge_load   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (merge_load) begin
         rsp_travel_ff <= merge_travel;
         rsp_flags_ff  <= merge_flags;
      end
   end

   dpsp_lane u_lane_a (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sample (req_sample_a),
      .lo     (a_min_ff),
      .hi     (a_max_ff),
      .margin (margin_ff),
      .result (lane_a)
   );

   dpsp_lane u_lane_b (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sample (req_sample_b),
      .lo     (b_min_ff),
      .hi     (b_max_ff),
      .margin (margin_ff),
      .result (lane_b)
   );

   dpsp_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .update          (merge_load),
      .ignore_errors   (IGNORE_ERRORS),
      .deviation_limit (dev_limit_ff),
      .fault_limit     (fault_limit_ff),
      .travel_deadzone (deadzone_ff),
      .lane_a          (lane_a),
      .lane_b          (lane_b),
      .travel          (merge_travel),
      .error_flags     (merge_flags)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_travel      = rsp_travel_ff;
   assign rsp_error_flags = rsp_flags_ff;

   `ASSERT_ALWAYS(a_lanes_lockstep, clock, reset, lane_a.done == lane_b.done)
   `ASSERT_NEXT(a_accept_runs, clock, reset, req_valid && req_ready, state_ff == ST_RUN)
   `ASSERT_NEXT(a_load_shows, clock, reset, merge_load, rsp_valid_ff)

endmodule
